// ----- hw/rtl/fcull_pkg.sv -----
// ----------------------------------------------------------------------------
// Frustum cull package
// Widths, test codes and the types that travel along the chain of plane cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fcull_pkg;

   // Coordinate and coefficient formats.
   localparam int COORD_BITS     = 16;
   localparam int COEF_BITS      = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int RAD_BITS       = 15;

   // Plane registers: A, B, C and D packed from the top down.
   localparam int NUM_PLANES   = 6;
   localparam int PLANE_BITS   = 4 * COEF_BITS;
   localparam int CSR_IDX_BITS = 3;

   // One coefficient by one coordinate, and the exact sum of three such
   // products plus the scaled offset.
   localparam int PROD_BITS = COEF_BITS + COORD_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;

   // Test kinds.
   localparam logic [1:0] FUNC_POINT  = 2'd0;
   localparam logic [1:0] FUNC_SPHERE = 2'd1;
   localparam logic [1:0] FUNC_BOX    = 2'd2;

   // One object under test, with its running verdict.
   typedef struct packed {
      logic [1:0]            func;
      logic [COORD_BITS-1:0] xa;
      logic [COORD_BITS-1:0] ya;
      logic [COORD_BITS-1:0] za;
      logic [COORD_BITS-1:0] xb;
      logic [COORD_BITS-1:0] yb;
      logic [COORD_BITS-1:0] zb;
      logic [RAD_BITS-1:0]   sphere_radius;
      logic                  visible;
   } item_type;

   // What one cell hands to the next.
   typedef struct packed {
      logic     valid;
      item_type item;
   } link_type;

endpackage

`default_nettype wire

// ----- hw/rtl/fcull_if.sv -----
// ----------------------------------------------------------------------------
// Frustum cull channels
// Valid/ready channels for the object words and the verdict words.
// ----------------------------------------------------------------------------
`default_nettype none

// Object word channel.
interface fcull_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        func;
   logic [fcull_pkg::COORD_BITS-1:0]  xa;
   logic [fcull_pkg::COORD_BITS-1:0]  ya;
   logic [fcull_pkg::COORD_BITS-1:0]  za;
   logic [fcull_pkg::COORD_BITS-1:0]  xb;
   logic [fcull_pkg::COORD_BITS-1:0]  yb;
   logic [fcull_pkg::COORD_BITS-1:0]  zb;
   logic [fcull_pkg::RAD_BITS-1:0]    sphere_radius;

   modport source (output valid, func, xa, ya, za, xb, yb, zb, sphere_radius,
                   input ready);
   modport sink (input valid, func, xa, ya, za, xb, yb, zb, sphere_radius,
                 output ready);
endinterface

// Verdict word channel.
interface fcull_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink (input valid, inside_res, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fcull_cell.sv -----
// ----------------------------------------------------------------------------
// Frustum cull plane cell
// Holds one clip plane and tests each passing object against it in two
// register stages: the three products, then the exact sum and the compare.
// ----------------------------------------------------------------------------
`default_nettype none

module fcull_cell (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             adv,
   input  wire logic                             plane_we,
   input  wire logic [fcull_pkg::PLANE_BITS-1:0] plane_wdata,
   input  wire fcull_pkg::link_type              link_in,
   output      fcull_pkg::link_type              link_out
);

   localparam int CB = fcull_pkg::COEF_BITS;
   localparam int XB = fcull_pkg::COORD_BITS;
   localparam int PB = fcull_pkg::PROD_BITS;
   localparam int SB = fcull_pkg::SUM_BITS;
   localparam int FB = fcull_pkg::COEF_FRAC_BITS;
   localparam int RB = fcull_pkg::RAD_BITS;

   logic [fcull_pkg::PLANE_BITS-1:0] plane_ff;

   logic signed [CB-1:0] coef_a, coef_b, coef_c, coef_d;
   logic signed [XB-1:0] sel_x, sel_y, sel_z;
   logic signed [PB-1:0] prod_a_in, prod_b_in, prod_c_in;
   logic                 is_box;

   logic                 s1_valid_ff;
   fcull_pkg::item_type  s1_item_ff;
   logic signed [PB-1:0] prod_a_ff, prod_b_ff, prod_c_ff;
   logic signed [CB-1:0] coef_d_ff;

   logic signed [SB-1:0] sum_in, lim_in;
   logic                 reject_in;
   fcull_pkg::item_type  s2_item_in;

   logic                 s2_valid_ff;
   fcull_pkg::item_type  s2_item_ff;

   // The plane this cell tests against.
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (plane_we) begin
         plane_ff <= plane_wdata;
      end
   end

   assign coef_a = $signed(plane_ff[4*CB-1 -: CB]);
   assign coef_b = $signed(plane_ff[3*CB-1 -: CB]);
   assign coef_c = $signed(plane_ff[2*CB-1 -: CB]);
   assign coef_d = $signed(plane_ff[CB-1:0]);

   // For a box the plane distance is largest at the corner that takes, on
   // each axis, the larger coordinate where the coefficient is not negative
   // and the smaller one otherwise. The box is outside when even that
   // corner is at or below the plane.
   always_comb begin
      is_box = (link_in.item.func == fcull_pkg::FUNC_BOX);
      sel_x  = $signed(link_in.item.xa);
      sel_y  = $signed(link_in.item.ya);
      sel_z  = $signed(link_in.item.za);
      if (is_box) begin
         if (($signed(link_in.item.xb) > $signed(link_in.item.xa)) == !coef_a[CB-1]) begin
            sel_x = $signed(link_in.item.xb);
         end
         if (($signed(link_in.item.yb) > $signed(link_in.item.ya)) == !coef_b[CB-1]) begin
            sel_y = $signed(link_in.item.yb);
         end
         if (($signed(link_in.item.zb) > $signed(link_in.item.za)) == !coef_c[CB-1]) begin
            sel_z = $signed(link_in.item.zb);
         end
      end
      prod_a_in = coef_a * sel_x;
      prod_b_in = coef_b * sel_y;
      prod_c_in = coef_c * sel_z;
   end

   // First stage: products.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= link_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff <= link_in.item;
         prod_a_ff  <= prod_a_in;
         prod_b_ff  <= prod_b_in;
         prod_c_ff  <= prod_c_in;
         coef_d_ff  <= coef_d;
      end
   end

   // Exact distance and the limit it must exceed: zero for points and
   // boxes, minus the scaled radius for spheres. An unknown kind is kept.
   always_comb begin
      sum_in = SB'(prod_a_ff) + SB'(prod_b_ff) + SB'(prod_c_ff)
             + $signed({{(SB-CB-FB){coef_d_ff[CB-1]}}, coef_d_ff, {FB{1'b0}}});
      lim_in = '0;
      if (s1_item_ff.func == fcull_pkg::FUNC_SPHERE) begin
         lim_in = -$signed({{(SB-RB-FB){1'b0}}, s1_item_ff.sphere_radius, {FB{1'b0}}});
      end
      reject_in = ((s1_item_ff.func == fcull_pkg::FUNC_POINT) ||
                   (s1_item_ff.func == fcull_pkg::FUNC_SPHERE) ||
                   (s1_item_ff.func == fcull_pkg::FUNC_BOX)) && !(sum_in > lim_in);
      s2_item_in         = s1_item_ff;
      s2_item_in.visible = s1_item_ff.visible & ~reject_in;
   end

   // Second stage: updated verdict.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign link_out.valid = s2_valid_ff;
   assign link_out.item  = s2_item_ff;

   // A word rejected by an earlier plane stays rejected.
   a_visible_sticky: assert property (@(posedge clock) disable iff (reset)
      (adv && s1_valid_ff && !s1_item_ff.visible) |=> !s2_item_ff.visible)
      else $error("fcull_cell: rejected word revived");

   // A word entering while the chain moves reaches the first stage.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (adv && link_in.valid) |=> s1_valid_ff)
      else $error("fcull_cell: word lost at entry");

   // A held chain keeps its words in place.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(s1_valid_ff) && $stable(s2_valid_ff)))
      else $error("fcull_cell: stage moved while held");

endmodule

`default_nettype wire

// ----- hw/rtl/frustum_cull_test.sv -----
// ----------------------------------------------------------------------------
// Frustum cull test
// Six-plane visibility test for points, spheres and axis-aligned boxes.
// ----------------------------------------------------------------------------
// The block takes one object word per clock cycle and returns one verdict word
// for each, in order. A verdict leaves through the output register once its
// word has passed six plane cells of two register stages each. When the output
// is held the whole chain holds with it, and a new word is still taken in any
// cycle where the output register is empty or is being emptied. The user must
// write planes through the csr_ port only while no word is in flight; the block
// does not enforce this. Indexes beyond the sixth plane are ignored.
`default_nettype none

module frustum_cull_test (
   input  wire logic                               clock,
   input  wire logic                               reset,
   fcull_req_if.sink                               req,
   fcull_rsp_if.source                             rsp,
   input  wire logic                               csr_we,
   input  wire logic [fcull_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [fcull_pkg::PLANE_BITS-1:0]   csr_wdata
);

   localparam int NP = fcull_pkg::NUM_PLANES;

   fcull_pkg::link_type link [NP+1];
   logic [NP-1:0]       plane_we;
   logic                adv;
   logic                rsp_valid_ff;
   logic                rsp_inside_ff;

   // The chain moves whenever the output register can take a word.
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   // Entry word: every object starts out visible.
   assign link[0].valid              = req.valid;
   assign link[0].item.func          = req.func;
   assign link[0].item.xa            = req.xa;
   assign link[0].item.ya            = req.ya;
   assign link[0].item.za            = req.za;
   assign link[0].item.xb            = req.xb;
   assign link[0].item.yb            = req.yb;
   assign link[0].item.zb            = req.zb;
   assign link[0].item.sphere_radius = req.sphere_radius;
   assign link[0].item.visible       = 1'b1;

   // One cell per plane, in register order.
   for (genvar i = 0; i < NP; i++) begin : g_cell
      assign plane_we[i] = csr_we && (csr_index == fcull_pkg::CSR_IDX_BITS'(i));

      fcull_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .adv         (adv),
         .plane_we    (plane_we[i]),
         .plane_wdata (csr_wdata),
         .link_in     (link[i]),
         .link_out    (link[i+1])
      );
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= link[NP].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_inside_ff <= link[NP].item.visible;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.inside_res = rsp_inside_ff;

   // A word leaving the last cell lands in the output register.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (adv && link[NP].valid) |=> rsp_valid_ff)
      else $error("frustum_cull_test: word lost at output");

   // A verdict that is not taken stays on the output unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.inside_res)))
      else $error("frustum_cull_test: waiting verdict changed");

   // An empty output register never blocks the input.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req.ready)
      else $error("frustum_cull_test: input blocked while output empty");

endmodule

`default_nettype wire
